// ===== hdl/lru_page_replacement_defines.svh =====
// assertion macros shared by the rtl
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define LRUPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru page replacement: assertion failed");

// next-cycle implication
`define LRUPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru page replacement: assertion failed");

`endif

// ===== hdl/lrupr_pkg.sv =====
package lrupr_pkg;

  localparam int unsigned DefFrames = 16;
  localparam int unsigned MaxFrames = 64;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CharW     = 8;
  localparam int unsigned PageW     = 6;
  localparam int unsigned CfgW      = 5;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned TotW      = 16;

  localparam logic [CfgW-1:0]  CfgReset   = CfgW'(DefFrames);
  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharNine   = 8'h39;
  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;
  localparam logic [PageW-1:0] LetterBase = 6'd10;
  localparam logic [TotW-1:0]  TotMax     = '1;

  // partial search result handed from cell to cell
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] hit_idx;
    logic [IdxW-1:0] hit_rank;
    logic            empty;
    logic [IdxW-1:0] empty_idx;
    logic [IdxW-1:0] best_idx;
    logic [IdxW-1:0] best_rank;
  } scan_t;

  // update broadcast to every cell
  typedef struct packed {
    logic            en;
    logic            age_all;
    logic [IdxW-1:0] slot;
    logic [IdxW-1:0] old_rank;
  } upd_t;

  typedef struct packed {
    logic             ok;
    logic [PageW-1:0] page;
  } dec_t;

  function automatic dec_t decode_char(input logic [CharW-1:0] c);
    dec_t d;
    d = '0;
    if (c >= CharZero && c <= CharNine) begin
      d.ok   = 1'b1;
      d.page = PageW'(c - CharZero);
    end else if (c >= CharUpperA && c <= CharUpperZ) begin
      d.ok   = 1'b1;
      d.page = PageW'(c - CharUpperA) + LetterBase;
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      d.ok   = 1'b1;
      d.page = PageW'(c - CharLowerA) + LetterBase;
    end
    return d;
  endfunction

endpackage

// ===== hdl/lrupr_cell.sv =====
module lrupr_cell #(
  parameter int unsigned FRAMES = lrupr_pkg::DefFrames,
  parameter int unsigned IDX    = 0,
  localparam int unsigned NW    = $clog2(FRAMES + 1),
  localparam int unsigned RW    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [NW-1:0]                 n_i,
  input  logic [lrupr_pkg::PageW-1:0]   page_i,
  input  lrupr_pkg::upd_t               upd_i,
  input  lrupr_pkg::scan_t              scan_i,
  output lrupr_pkg::scan_t              scan_o
);

  localparam logic [RW-1:0] RankMax = RW'(FRAMES - 1);

  logic [lrupr_pkg::PageW-1:0] page_q;
  logic                        valid_q;
  logic [RW-1:0]               rank_q;
  lrupr_pkg::scan_t            scan_d, scan_q;
  logic                        active;
  logic                        me;
  logic [lrupr_pkg::IdxW-1:0]  rank_ext;

  assign active   = 32'(n_i) > IDX;
  assign me       = upd_i.slot == lrupr_pkg::IdxW'(IDX);
  assign rank_ext = lrupr_pkg::IdxW'(rank_q);
  assign scan_o   = scan_q;

  always_comb begin
    scan_d = scan_i;
    if (active) begin
      if (!scan_i.hit && valid_q && page_q == page_i) begin
        scan_d.hit      = 1'b1;
        scan_d.hit_idx  = lrupr_pkg::IdxW'(IDX);
        scan_d.hit_rank = rank_ext;
      end
      if (!scan_i.empty && !valid_q) begin
        scan_d.empty     = 1'b1;
        scan_d.empty_idx = lrupr_pkg::IdxW'(IDX);
      end
      // strictly older only, so the lower index keeps a tie
      if (rank_ext > scan_i.best_rank) begin
        scan_d.best_idx  = lrupr_pkg::IdxW'(IDX);
        scan_d.best_rank = rank_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      valid_q <= 1'b0;
      rank_q  <= '0;
      scan_q  <= '0;
    end else begin
      scan_q <= scan_d;
      if (upd_i.en && active) begin
        if (me) begin
          page_q  <= page_i;
          valid_q <= 1'b1;
          rank_q  <= '0;
        end else if (valid_q && (upd_i.age_all || rank_ext < upd_i.old_rank) &&
                     rank_q != RankMax) begin
          rank_q <= rank_q + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/lru_page_replacement.sv =====
// lru page replacement over a chain of frame cells
// a page item is latched in IDLE, searched in SCAN by a wave that moves one cell per
// cycle down the chain and applied in UPDATE; no new item is taken until then, and
// out_stall_i can hold UPDATE; skipped characters are taken without leaving IDLE
// reset: asynchronous active low, all frames empty, totals zero, frame cfg 16 (at most FRAMES)
`include "lru_page_replacement_defines.svh"

module lru_page_replacement #(
  parameter int unsigned FRAMES = lrupr_pkg::DefFrames
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lrupr_pkg::CharW-1:0]  ref_char_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [lrupr_pkg::SlotW-1:0]  frame_slot_o,
  output logic [lrupr_pkg::TotW-1:0]   fault_count_o,
  output logic [lrupr_pkg::TotW-1:0]   hit_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lrupr_pkg::CfgW-1:0]   cfg_data_i
);

  localparam int unsigned NW = $clog2(FRAMES + 1);
  localparam int unsigned CW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    UPDATE
  } state_e;

  state_e                        state_q;
  logic [CW-1:0]                 cnt_q;
  logic [lrupr_pkg::PageW-1:0]   page_q;
  logic [lrupr_pkg::CfgW-1:0]    cfg_q;
  logic [NW-1:0]                 n_act;
  logic [lrupr_pkg::TotW-1:0]    fault_q, hit_q;
  logic                          out_valid_q, hit_q_o;
  logic [lrupr_pkg::SlotW-1:0]   slot_q;
  lrupr_pkg::dec_t               dec;
  lrupr_pkg::scan_t              chain [FRAMES+1];
  lrupr_pkg::scan_t              res;
  lrupr_pkg::upd_t               upd;
  logic                          in_acc;

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = state_q != IDLE;
  assign in_acc        = in_valid_i && !in_stall_o;
  assign dec           = lrupr_pkg::decode_char(ref_char_i);
  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q_o;
  assign frame_slot_o  = slot_q;
  assign fault_count_o = fault_q;
  assign hit_count_o   = hit_q;

  always_comb begin
    if (cfg_q == '0) begin
      n_act = NW'(1);
    end else if (32'(cfg_q) > FRAMES) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = NW'(cfg_q);
    end
  end

  assign chain[0] = '0;
  assign res      = chain[FRAMES];

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrupr_cell #(
      .FRAMES (FRAMES),
      .IDX    (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .n_i    (n_act),
      .page_i (page_q),
      .upd_i  (upd),
      .scan_i (chain[i]),
      .scan_o (chain[i+1])
    );
  end

  // decide the touched frame once the wave has left the last cell
  always_comb begin
    upd.en       = (state_q == UPDATE) && !(out_valid_q && out_stall_i);
    upd.age_all  = 1'b0;
    upd.slot     = res.best_idx;
    upd.old_rank = res.best_rank;
    if (res.hit) begin
      upd.slot     = res.hit_idx;
      upd.old_rank = res.hit_rank;
    end else if (res.empty) begin
      upd.slot    = res.empty_idx;
      upd.age_all = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      page_q      <= '0;
      cfg_q       <= lrupr_pkg::CfgReset;
      fault_q     <= '0;
      hit_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q_o     <= 1'b0;
      slot_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (upd.en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_acc && dec.ok) begin
            page_q  <= dec.page;
            cnt_q   <= '0;
            state_q <= SCAN;
          end
        end
        SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(FRAMES - 1)) begin
            state_q <= UPDATE;
          end
        end
        UPDATE: begin
          if (upd.en) begin
            hit_q_o <= res.hit;
            slot_q  <= upd.slot[lrupr_pkg::SlotW-1:0];
            if (res.hit) begin
              if (hit_q != lrupr_pkg::TotMax) hit_q <= hit_q + 1'b1;
            end else begin
              if (fault_q != lrupr_pkg::TotMax) fault_q <= fault_q + 1'b1;
            end
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  `LRUPR_ASSERT_NXT(a_page_starts_scan, clk_i, rst_ni, in_acc && dec.ok,
                    state_q == SCAN && cnt_q == '0)
  `LRUPR_ASSERT_IMP(a_slot_active, clk_i, rst_ni, state_q == UPDATE,
                    32'(upd.slot) < 32'(n_act))
  `LRUPR_ASSERT_NXT(a_totals_grow, clk_i, rst_ni, 1'b1,
                    fault_q >= $past(fault_q) && hit_q >= $past(hit_q))

endmodule
